// File: design/lleval_pkg.sv
// Shared constants, codes and handshake structs for the Leja Lagrange basis evaluator.
package lleval_pkg;

    localparam int NODE_COUNT = 64;
    localparam int FRAC_BITS  = 24;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int INT_BITS   = 32 - FRAC_BITS;
    localparam int DIV_STEPS  = 32;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int PM_W       = 64 - FRAC_BITS;

    localparam logic [31:0] FIX_ONE   = 32'd1 << FRAC_BITS;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SAT      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

    typedef struct packed {
        logic accept;
        logic sel_k;
        logic cap_nodek;
        logic cap_term;
        logic div_init;
        logic div_step;
        logic q_clamp;
        logic mul;
        logic acc;
        logic zero_den;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic k_zero;
        logic den_zero;
        logic big;
        logic div_last;
        logic term_last;
    } dp_status_t;

endpackage

// File: design/lleval_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lleval_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/lleval_datapath.sv
// Datapath: node table, term subtractors, iterative divider, multiplier and saturation.
module lleval_datapath (
    input  logic                clk,
    input  lleval_pkg::cmd_t    cmd,
    output lleval_pkg::dp_status_t st,
    input  logic                operation,
    input  logic [5:0]          node_index,
    input  logic signed [31:0]  operand_value,
    output logic signed [31:0]  basis_value,
    output logic [1:0]          status
);

    logic [lleval_pkg::IDX_W-1:0] k_reg, k_next;
    logic [lleval_pkg::IDX_W-1:0] i_reg, i_next;
    logic [lleval_pkg::IDX_W-1:0] in_idx;
    logic [lleval_pkg::IDX_W-1:0] rd_addr;
    logic [31:0]                  rd_data;
    logic [31:0] t_reg, t_next;
    logic [31:0] nodek_reg, nodek_next;
    logic [31:0] absnum_reg, absnum_next;
    logic [31:0] absden_reg, absden_next;
    logic        qneg_reg, qneg_next;
    logic        den_zero_reg, den_zero_next;
    logic        big_reg, big_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] quo_reg, quo_next;
    logic [lleval_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] qmag_reg, qmag_next;
    logic        qsign_reg, qsign_next;
    logic [63:0] prodfull_reg, prodfull_next;
    logic        pneg_reg, pneg_next;
    logic [31:0] prod_mag_reg, prod_mag_next;
    logic        prod_neg_reg, prod_neg_next;
    logic        sat_reg, sat_next;
    logic        dz_reg, dz_next;
    logic [31:0] basis_reg, basis_next;
    logic [1:0]  status_reg, status_next;

    logic signed [32:0] num_w;
    logic signed [32:0] den_w;
    logic [32:0]        trial;
    logic               big_w;
    logic               qneg_eff;
    logic [31:0]        qlimit;
    logic [lleval_pkg::PM_W-1:0] pm;
    logic               pm_neg;
    logic [31:0]        plimit;

    assign in_idx  = lleval_pkg::IDX_W'(node_index % lleval_pkg::NODE_COUNT);
    assign rd_addr = cmd.sel_k ? k_reg : i_reg;

    lleval_ram #(
        .WIDTH (32),
        .DEPTH (lleval_pkg::NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .we      (cmd.accept && (operation == lleval_pkg::OP_LOAD)),
        .wr_addr (in_idx),
        .wr_data (operand_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign num_w = {t_reg[31], t_reg} - {rd_data[31], rd_data};
    assign den_w = {nodek_reg[31], nodek_reg} - {rd_data[31], rd_data};
    assign big_w = {{lleval_pkg::INT_BITS{1'b0}}, absnum_reg}
                   >= {absden_reg, {lleval_pkg::INT_BITS{1'b0}}};
    assign trial = {rem_reg, dvd_reg[31]} - {1'b0, absden_reg};

    assign qneg_eff = qneg_reg && (big_reg || (quo_reg != 32'd0));
    assign qlimit   = qneg_eff ? lleval_pkg::NEG_LIMIT : lleval_pkg::POS_LIMIT;
    assign pm       = prodfull_reg[63:lleval_pkg::FRAC_BITS];
    assign pm_neg   = pneg_reg && (pm != '0);
    assign plimit   = pm_neg ? lleval_pkg::NEG_LIMIT : lleval_pkg::POS_LIMIT;

    assign st.k_zero    = (k_reg == '0);
    assign st.den_zero  = den_zero_reg;
    assign st.big       = big_reg;
    assign st.div_last  = (cnt_reg == lleval_pkg::CNT_W'(lleval_pkg::DIV_STEPS - 1));
    assign st.term_last = (lleval_pkg::IDX_W'(i_reg + 1'b1) == k_reg);

    always_comb
    begin
        k_next        = k_reg;
        i_next        = i_reg;
        t_next        = t_reg;
        nodek_next    = nodek_reg;
        absnum_next   = absnum_reg;
        absden_next   = absden_reg;
        qneg_next     = qneg_reg;
        den_zero_next = den_zero_reg;
        big_next      = big_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        qmag_next     = qmag_reg;
        qsign_next    = qsign_reg;
        prodfull_next = prodfull_reg;
        pneg_next     = pneg_reg;
        prod_mag_next = prod_mag_reg;
        prod_neg_next = prod_neg_reg;
        sat_next      = sat_reg;
        dz_next       = dz_reg;
        basis_next    = basis_reg;
        status_next   = status_reg;

        if (cmd.accept)
        begin
            k_next        = in_idx;
            t_next        = operand_value;
            i_next        = '0;
            prod_neg_next = 1'b0;
            prod_mag_next = (operation == lleval_pkg::OP_EVAL) ? lleval_pkg::FIX_ONE : 32'd0;
            sat_next      = 1'b0;
            dz_next       = 1'b0;
        end

        if (cmd.cap_nodek)
        begin
            nodek_next = rd_data;
        end

        if (cmd.cap_term)
        begin
            absnum_next   = num_w[32] ? 32'(-num_w) : num_w[31:0];
            absden_next   = den_w[32] ? 32'(-den_w) : den_w[31:0];
            qneg_next     = num_w[32] ^ den_w[32];
            den_zero_next = (den_w == '0);
        end

        if (cmd.zero_den)
        begin
            dz_next = 1'b1;
        end

        if (cmd.div_init)
        begin
            big_next = big_w;
            rem_next = absnum_reg >> lleval_pkg::INT_BITS;
            dvd_next = 32'(absnum_reg << lleval_pkg::FRAC_BITS);
            quo_next = '0;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = trial[32] ? {rem_reg[30:0], dvd_reg[31]} : trial[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], ~trial[32]};
            cnt_next = lleval_pkg::CNT_W'(cnt_reg + 1'b1);
        end

        if (cmd.q_clamp)
        begin
            qsign_next = qneg_eff;
            if (big_reg || (quo_reg > qlimit))
            begin
                qmag_next = qlimit;
                sat_next  = 1'b1;
            end
            else
            begin
                qmag_next = quo_reg;
            end
        end

        if (cmd.mul)
        begin
            prodfull_next = 64'(prod_mag_reg) * 64'(qmag_reg);
            pneg_next     = prod_neg_reg ^ qsign_reg;
        end

        if (cmd.acc)
        begin
            prod_neg_next = pm_neg;
            if (pm > lleval_pkg::PM_W'(plimit))
            begin
                prod_mag_next = plimit;
                sat_next      = 1'b1;
            end
            else
            begin
                prod_mag_next = pm[31:0];
            end
            i_next = lleval_pkg::IDX_W'(i_reg + 1'b1);
        end

        if (cmd.commit)
        begin
            if (dz_reg)
            begin
                basis_next  = 32'd0;
                status_next = lleval_pkg::STATUS_ZERO_DEN;
            end
            else
            begin
                basis_next  = prod_neg_reg ? 32'(-prod_mag_reg) : prod_mag_reg;
                status_next = sat_reg ? lleval_pkg::STATUS_SAT : lleval_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        i_reg        <= i_next;
        t_reg        <= t_next;
        nodek_reg    <= nodek_next;
        absnum_reg   <= absnum_next;
        absden_reg   <= absden_next;
        qneg_reg     <= qneg_next;
        den_zero_reg <= den_zero_next;
        big_reg      <= big_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        qmag_reg     <= qmag_next;
        qsign_reg    <= qsign_next;
        prodfull_reg <= prodfull_next;
        pneg_reg     <= pneg_next;
        prod_mag_reg <= prod_mag_next;
        prod_neg_reg <= prod_neg_next;
        sat_reg      <= sat_next;
        dz_reg       <= dz_next;
        basis_reg    <= basis_next;
        status_reg   <= status_next;
    end

    assign basis_value = basis_reg;
    assign status      = status_reg;

endmodule

// File: design/lleval_ctrl.sv
// Controller state machine: sequences node reads, division steps, multiply and output handoff.
module lleval_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  lleval_pkg::dp_status_t st,
    output lleval_pkg::cmd_t       cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RDK   = 11'b00000000010,
        S_WAITK = 11'b00000000100,
        S_RDI   = 11'b00000001000,
        S_CHK   = 11'b00000010000,
        S_PRE   = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_QCL   = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_ACC   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (operation == lleval_pkg::OP_LOAD) ? S_FIN : S_RDK;
                end
            end
            S_RDK:
            begin
                cmd.sel_k  = 1'b1;
                state_next = S_WAITK;
            end
            S_WAITK:
            begin
                cmd.cap_nodek = 1'b1;
                state_next    = st.k_zero ? S_FIN : S_RDI;
            end
            S_RDI:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.cap_term = 1'b1;
                state_next   = S_PRE;
            end
            S_PRE:
            begin
                if (st.den_zero)
                begin
                    cmd.zero_den = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (st.big)
                begin
                    state_next = S_QCL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (st.div_last)
                    begin
                        state_next = S_QCL;
                    end
                end
            end
            S_QCL:
            begin
                cmd.q_clamp = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = st.term_last ? S_FIN : S_RDI;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/leja_lagrange_basis_eval_core.sv
// Top level of the Leja Lagrange basis evaluator: controller plus datapath.
// Load item: accepted in idle, result committed from the finish state once the output is free.
// Evaluate item, per term: node read and setup, 32-step restoring divide, then clamp, multiply, add;
// a term whose quotient overflows skips the divide steps; a zero denominator ends the loop.
// One item in flight; next item accepted the cycle after the result is registered.
// Reset (rst_n low, async) returns the controller to idle and drops out_valid; node table is kept.
module leja_lagrange_basis_eval_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [5:0]         node_index,
    input  logic signed [31:0] operand_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] basis_value,
    output logic [1:0]         status
);

    lleval_pkg::cmd_t       cmd;
    lleval_pkg::dp_status_t st;

    lleval_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    lleval_datapath u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .st            (st),
        .operation     (operation),
        .node_index    (node_index),
        .operand_value (operand_value),
        .basis_value   (basis_value),
        .status        (status)
    );

endmodule

// File: design/lleval_checker.sv
// Port-level assertions for the Leja Lagrange basis evaluator, bound to the top level.
module lleval_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] basis_value,
    input logic [1:0]         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(basis_value) && $stable(status))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before result was handed off");

    a_zero_den_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lleval_pkg::STATUS_ZERO_DEN) |-> basis_value == 32'sd0)
        else $error("zero denominator result not zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lleval_pkg::STATUS_OK) || (status == lleval_pkg::STATUS_SAT)
                      || (status == lleval_pkg::STATUS_ZERO_DEN))
        else $error("undefined status code");

endmodule

bind leja_lagrange_basis_eval_core lleval_checker u_lleval_checker (.*);

// File: sim/leja_basis_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the Leja Lagrange basis evaluator: keeps a node table, predicts each result, checks it.
module leja_basis_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               operation,
    input  logic [5:0]         node_index,
    input  logic signed [31:0] operand_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] basis_value,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         code;
    } basis_t;

    logic signed [31:0] node_copy [lleval_pkg::NODE_COUNT];
    basis_t             basis_due_q [$];

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic neg, input logic [63:0] m,
                                                  inout logic sat);
        logic [63:0] limit;
        limit = neg ? {32'd0, lleval_pkg::NEG_LIMIT} : {32'd0, lleval_pkg::POS_LIMIT};
        if (m > limit)
        begin
            m   = limit;
            sat = 1'b1;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic basis_t lagrange_basis_at(input logic [lleval_pkg::IDX_W-1:0] k,
                                                 input logic signed [31:0] t);
        basis_t             r;
        logic signed [63:0] prod;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [63:0] q;
        logic [63:0]        qm;
        logic [63:0]        pm;
        logic               qneg;
        logic               pneg;
        logic               sat;
        int                 i;
        prod = $signed({32'd0, lleval_pkg::FIX_ONE});
        sat  = 1'b0;
        for (i = 0; i < k; i++)
        begin
            num = t - node_copy[lleval_pkg::IDX_W'(i)];
            den = node_copy[k] - node_copy[lleval_pkg::IDX_W'(i)];
            if (den == 0)
            begin
                r.value = '0;
                r.code  = lleval_pkg::STATUS_ZERO_DEN;
                return r;
            end
            qneg = (num < 0) != (den < 0);
            qm   = (mag64(num) << lleval_pkg::FRAC_BITS) / mag64(den);
            if (qm == 0)
                qneg = 1'b0;
            q    = clamp32(qneg, qm, sat);
            pneg = (prod < 0) != (q < 0);
            pm   = (mag64(prod) * mag64(q)) >> lleval_pkg::FRAC_BITS;
            if (pm == 0)
                pneg = 1'b0;
            prod = clamp32(pneg, pm, sat);
        end
        r.value = prod[31:0];
        r.code  = sat ? lleval_pkg::STATUS_SAT : lleval_pkg::STATUS_OK;
        return r;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        basis_t                       want;
        logic [lleval_pkg::IDX_W-1:0] slot;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (basis_due_q.size() == 0)
                begin
                    fail_count++;
                    $error("result with no item pending: basis_value %0d, status %0d",
                           basis_value, status);
                end
                else
                begin
                    want = basis_due_q.pop_front();
                    if (basis_value !== want.value)
                    begin
                        fail_count++;
                        $error("basis_value mismatch: expected %0d, actual %0d",
                               want.value, basis_value);
                    end
                    if (status !== want.code)
                    begin
                        fail_count++;
                        $error("status mismatch: expected %0d, actual %0d", want.code, status);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                slot = lleval_pkg::IDX_W'(node_index % lleval_pkg::NODE_COUNT);
                if (operation == lleval_pkg::OP_LOAD)
                begin
                    node_copy[slot] = operand_value;
                    want.value = '0;
                    want.code  = lleval_pkg::STATUS_OK;
                end
                else
                    want = lagrange_basis_at(slot, operand_value);
                basis_due_q = {basis_due_q, want};
            end
            pending_count = basis_due_q.size();
        end
    end

endmodule

// File: sim/leja_lagrange_basis_eval_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the Leja Lagrange basis evaluator: clock, reset, stimulus and verdict.
module leja_lagrange_basis_eval_core_test;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic [5:0]         node_index;
    logic signed [31:0] operand_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] basis_value;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending_count;

    logic [lleval_pkg::NODE_COUNT-1:0] written;
    logic signed [31:0]                node_shadow [lleval_pkg::NODE_COUNT];
    logic                              quiet;
    int                                sent;

    leja_lagrange_basis_eval_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .node_index    (node_index),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .basis_value   (basis_value),
        .status        (status)
    );

    leja_basis_scoreboard u_score (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .node_index    (node_index),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .basis_value   (basis_value),
        .status        (status),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("[leja_lagrange_basis_eval_core] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int filled_prefix();
        int n;
        n = 0;
        while (n < lleval_pkg::NODE_COUNT && written[lleval_pkg::IDX_W'(n)])
            n++;
        return n;
    endfunction

    function automatic logic signed [31:0] near_zero(input logic [31:0] span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic send_item(input logic op, input logic [5:0] idx,
                             input logic signed [31:0] val);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        node_index    <= idx;
        operand_value <= val;
        if (op == lleval_pkg::OP_LOAD)
        begin
            written[idx]     = 1'b1;
            node_shadow[idx] = val;
        end
        sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // result side: stall in bursts, with long free stretches
    initial
    begin
        int stall_len;
        int run_len;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            stall_len = pick_gap();
            run_len   = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat (run_len) @(negedge clk);
        end
    end

    initial
    begin
        int                 round;
        int                 n;
        int                 j;
        int                 k;
        int                 evals;
        int                 pre;
        int                 sel;
        int                 tries;
        logic [31:0]        span;
        logic signed [31:0] v;
        logic signed [31:0] t;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = lleval_pkg::OP_LOAD;
        node_index    = '0;
        operand_value = '0;
        written       = '0;
        quiet         = 1'b0;
        sent          = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nodes 1, -1, 0, 0.5, -0.5 and 0.75 on [-1, 1]
        send_item(lleval_pkg::OP_LOAD, 6'd0, 32'sh0100_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd1, 32'shFF00_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd2, 32'sh0000_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd3, 32'sh0080_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd4, 32'shFF80_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd5, 32'sh00C0_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd0, 32'sh7FFF_FFFF);
        send_item(lleval_pkg::OP_EVAL, 6'd1, 32'sh0000_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd3, 32'sh0040_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd5, 32'sh0080_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd5, 32'sh00C0_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd5, 32'sh7FFF_FFFF);
        send_item(lleval_pkg::OP_EVAL, 6'd4, 32'sh8000_0000);
        // repeated node: zero denominator
        send_item(lleval_pkg::OP_LOAD, 6'd6, 32'sh0080_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd6, 32'sh0020_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd7, 32'sh7FFF_FFFF);
        send_item(lleval_pkg::OP_EVAL, 6'd7, 32'sh0000_0000);
        send_item(lleval_pkg::OP_LOAD, 6'd63, 32'sh8000_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd0, 32'sh8000_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd2, 32'sh8000_0000);
        send_item(lleval_pkg::OP_EVAL, 6'd1, 32'sh7FFF_FFFF);
        drain_results();

        round = 0;
        while (sent < 260)
        begin
            if ($urandom_range(0, 3) == 0)
                drain_results();
            quiet = ($urandom_range(0, 3) == 0);
            n     = (round == 2 || $urandom_range(0, 24) == 0) ? lleval_pkg::NODE_COUNT
                                                               : $urandom_range(2, 10);
            span  = 32'd1 << $urandom_range(16, 30);
            for (j = 0; j < n; j++)
            begin
                if (j > 0 && $urandom_range(0, 39) == 0)
                    v = node_shadow[lleval_pkg::IDX_W'($urandom_range(0, j - 1))];
                else
                begin
                    tries = 0;
                    do
                    begin
                        v = near_zero(span);
                        tries++;
                        for (k = 0; k < j; k++)
                            if (node_shadow[lleval_pkg::IDX_W'(k)] == v)
                                v = '0;
                    end
                    while (v == '0 && j > 0 && tries < 8);
                end
                send_item(lleval_pkg::OP_LOAD, j[5:0], v);
            end
            evals = (n == lleval_pkg::NODE_COUNT) ? 3 : $urandom_range(3, 9);
            for (j = 0; j < evals; j++)
            begin
                if (n == lleval_pkg::NODE_COUNT && j == 0)
                    k = lleval_pkg::NODE_COUNT - 1;
                else if (n == lleval_pkg::NODE_COUNT)
                    k = $urandom_range(0, 12);
                else
                    k = $urandom_range(0, n - 1);
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    t = $urandom;
                else if (sel < 4)
                    t = node_shadow[lleval_pkg::IDX_W'($urandom_range(0, n - 1))]
                        + (near_zero(span) >>> 4);
                else
                    t = near_zero(span);
                send_item(lleval_pkg::OP_EVAL, k[5:0], t);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                pre = filled_prefix();
                if ($urandom_range(0, 1) == 0)
                    send_item(lleval_pkg::OP_LOAD,
                              6'($urandom_range(0, lleval_pkg::NODE_COUNT - 1)), $urandom);
                else
                    send_item(lleval_pkg::OP_EVAL,
                              6'((pre == 0) ? 0 : $urandom_range(0, pre - 1)), $urandom);
            end
            round++;
        end

        drain_results();
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("[leja_lagrange_basis_eval_core] OK");
        else
            $display("[leja_lagrange_basis_eval_core] ERROR");
        $finish;
    end

endmodule
